@@ rtl/core/lut3d_pkg.sv @@
// shared constants, types and helpers for the 3d lut color transform
`timescale 1ns / 1ps

package lut3d_pkg;

    localparam int MaxGrid      = 33;
    localparam int TableDepth   = MaxGrid * MaxGrid * MaxGrid;
    localparam int AddrW        = $clog2(TableDepth);
    localparam int ChanW        = 16;
    localparam int NodeW        = 3 * ChanW;
    localparam int GridW        = 6;
    localparam int Corners      = 8;
    localparam int QueueDepth   = 8;
    localparam int QueuePtrW    = $clog2(QueueDepth);
    localparam int FrontStages  = 4;

    localparam logic [GridW-1:0] GridReset = GridW'(17);
    localparam logic [ChanW-1:0] FullScale = 16'hFFFF;

    typedef enum logic {
        FUNC_LOAD      = 1'b0,
        FUNC_TRANSFORM = 1'b1
    } func_t;

    typedef struct packed {
        func_t                            func;
        logic                             ld_ok;
        logic [Corners-1:0][AddrW-1:0]    addr;
        logic [2:0][ChanW-1:0]            wt;
        logic [NodeW-1:0]                 data;
    } queue_entry_t;

    function automatic logic [GridW-1:0] grid_in_use(input logic [GridW-1:0] g);
        logic [GridW-1:0] r;
        r = g;
        if (g < GridW'(2)) r = GridW'(2);
        if (g > GridW'(MaxGrid)) r = GridW'(MaxGrid);
        return r;
    endfunction

endpackage

@@ rtl/core/lut3d_ram.sv @@
// one node table copy, one write port and one registered read port
`timescale 1ns / 1ps

module lut3d_ram (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [lut3d_pkg::AddrW-1:0]   waddr,
    input  logic [lut3d_pkg::NodeW-1:0]   wdata,
    input  logic                          re,
    input  logic [lut3d_pkg::AddrW-1:0]   raddr,
    output logic [lut3d_pkg::NodeW-1:0]   rdata
);
    import lut3d_pkg::*;

    logic [NodeW-1:0] mem [0:TableDepth-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/lut3d_queue.sv @@
// short queue between address generation and interpolation
`timescale 1ns / 1ps

module lut3d_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  lut3d_pkg::queue_entry_t           push_data,
    input  logic                              pop,
    output lut3d_pkg::queue_entry_t           pop_data,
    output logic                              empty,
    output logic [lut3d_pkg::QueuePtrW:0]     count
);
    import lut3d_pkg::*;

    queue_entry_t         store [0:QueueDepth-1];
    logic [QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
        end
    end

    assign pop_data = store[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

@@ rtl/core/lut3d_front.sv @@
// front: accepts beats, splits colors into nodes and weights, builds corner addresses
`timescale 1ns / 1ps

module lut3d_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  lut3d_pkg::func_t                  in_func,
    input  logic [15:0]                       in_index,
    input  logic [lut3d_pkg::NodeW-1:0]       in_entry,
    input  logic [2:0][lut3d_pkg::ChanW-1:0]  in_color,
    input  logic [lut3d_pkg::GridW-1:0]       grid,
    output logic                              push,
    output lut3d_pkg::queue_entry_t           push_data
);
    import lut3d_pkg::*;

    localparam int SW = ChanW + GridW;

    logic [FrontStages-1:0] vld_reg;

    // stage 1
    func_t                   f1_func_reg;
    logic                    f1_ok_reg;
    logic [AddrW-1:0]        f1_index_reg;
    logic [NodeW-1:0]        f1_data_reg;
    logic [2:0][SW-1:0]      f1_s_reg;
    logic [GridW-1:0]        f1_g_reg;
    // stage 2
    func_t                   f2_func_reg;
    logic                    f2_ok_reg;
    logic [AddrW-1:0]        f2_index_reg;
    logic [NodeW-1:0]        f2_data_reg;
    logic [2:0][GridW-1:0]   f2_lo_reg, f2_hi_reg, f2_lo_next, f2_hi_next;
    logic [2:0][ChanW-1:0]   f2_w_reg, f2_w_next;
    logic [GridW-1:0]        f2_g_reg;
    // stage 3
    func_t                   f3_func_reg;
    logic                    f3_ok_reg;
    logic [AddrW-1:0]        f3_index_reg;
    logic [NodeW-1:0]        f3_data_reg;
    logic [3:0][10:0]        f3_row_reg, f3_row_next;
    logic [GridW-1:0]        f3_blo_reg, f3_bhi_reg, f3_g_reg;
    logic [2:0][ChanW-1:0]   f3_w_reg;
    // stage 4
    queue_entry_t            f4_reg, f4_next;

    always_comb begin
        logic [GridW-1:0] q0;
        logic [ChanW:0]   rem;
        logic             ge;
        logic [GridW-1:0] lo, lo1;
        for (int k = 0; k < 3; k++) begin
            q0  = f1_s_reg[k][SW-1:ChanW];
            rem = {1'b0, f1_s_reg[k][ChanW-1:0]} + (ChanW+1)'(q0);
            ge  = (rem >= {1'b0, FullScale});
            lo  = q0 + GridW'(ge);
            f2_w_next[k] = ge ? ChanW'(rem - {1'b0, FullScale}) : rem[ChanW-1:0];
            lo1 = lo + 1'b1;
            f2_hi_next[k] = (lo1 < f1_g_reg) ? lo1 : f1_g_reg - 1'b1;
            f2_lo_next[k] = (lo > f1_g_reg - 1'b1) ? f1_g_reg - 1'b1 : lo;
        end
    end

    always_comb begin
        logic [GridW-1:0] r, gr;
        for (int j = 0; j < 4; j++) begin
            r  = j[1] ? f2_hi_reg[0] : f2_lo_reg[0];
            gr = j[0] ? f2_hi_reg[1] : f2_lo_reg[1];
            f3_row_next[j] = 11'(r) * 11'(f2_g_reg) + 11'(gr);
        end
    end

    always_comb begin
        f4_next.func  = f3_func_reg;
        f4_next.ld_ok = f3_ok_reg;
        f4_next.wt    = f3_w_reg;
        f4_next.data  = f3_data_reg;
        for (int k = 0; k < Corners; k++) begin
            f4_next.addr[k] = AddrW'(f3_row_reg[k[2:1]]) * AddrW'(f3_g_reg)
                              + AddrW'(k[0] ? f3_bhi_reg : f3_blo_reg);
        end
        if (f3_func_reg == FUNC_LOAD) begin
            f4_next.addr[0] = f3_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_func_reg  <= in_func;
            f1_ok_reg    <= (in_index < 16'(TableDepth));
            f1_index_reg <= AddrW'(in_index);
            f1_data_reg  <= in_entry;
            f1_g_reg     <= grid;
            for (int k = 0; k < 3; k++) begin
                f1_s_reg[k] <= SW'(in_color[k]) * SW'(grid - 1'b1);
            end
            f2_func_reg  <= f1_func_reg;
            f2_ok_reg    <= f1_ok_reg;
            f2_index_reg <= f1_index_reg;
            f2_data_reg  <= f1_data_reg;
            f2_lo_reg    <= f2_lo_next;
            f2_hi_reg    <= f2_hi_next;
            f2_w_reg     <= f2_w_next;
            f2_g_reg     <= f1_g_reg;
            f3_func_reg  <= f2_func_reg;
            f3_ok_reg    <= f2_ok_reg;
            f3_index_reg <= f2_index_reg;
            f3_data_reg  <= f2_data_reg;
            f3_row_reg   <= f3_row_next;
            f3_blo_reg   <= f2_lo_reg[2];
            f3_bhi_reg   <= f2_hi_reg[2];
            f3_g_reg     <= f2_g_reg;
            f3_w_reg     <= f2_w_reg;
            f4_reg       <= f4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FrontStages-2:0], in_valid};
        end
    end

    assign push      = en && vld_reg[FrontStages-1];
    assign push_data = f4_reg;

endmodule

@@ rtl/core/lut3d_blend.sv @@
// two-stage blend a + (b - a) * w / 65535, truncated toward zero
`timescale 1ns / 1ps

module lut3d_blend (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [lut3d_pkg::ChanW-1:0]   a,
    input  logic [lut3d_pkg::ChanW-1:0]   b,
    input  logic [lut3d_pkg::ChanW-1:0]   w,
    output logic [lut3d_pkg::ChanW-1:0]   y
);
    import lut3d_pkg::*;

    localparam int PW = 2 * ChanW + 2;

    logic signed [PW-1:0] prod_reg;
    logic [ChanW-1:0]     a_reg;
    logic signed [ChanW:0] diff;
    logic [PW-1:0]        mag;
    logic [ChanW-1:0]     q0, quot;
    logic [ChanW:0]       rem;
    logic                 neg;

    assign diff = signed'({1'b0, b}) - signed'({1'b0, a});

    always_comb begin
        neg  = prod_reg[PW-1];
        mag  = neg ? PW'(-prod_reg) : PW'(prod_reg);
        q0   = mag[2*ChanW-1:ChanW];
        rem  = {1'b0, mag[ChanW-1:0]} + {1'b0, q0};
        quot = q0 + ChanW'(rem >= {1'b0, FullScale});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(diff) * PW'(signed'({1'b0, w}));
            a_reg    <= a;
            y        <= neg ? a_reg - quot : a_reg + quot;
        end
    end

endmodule

@@ rtl/core/lut3d_back.sv @@
// back: corner reads from replicated node tables and three blend levels
`timescale 1ns / 1ps

module lut3d_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  lut3d_pkg::queue_entry_t           q_data,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lut3d_pkg::NodeW-1:0]       m_data
);
    import lut3d_pkg::*;

    localparam int BackStages = 7;

    logic                          en;
    logic                          is_xf, we;
    logic [BackStages-1:0]         vld_reg;
    logic [Corners-1:0][NodeW-1:0] corner;
    logic [2:0][ChanW-1:0]         w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;
    logic [2:0][3:0][ChanW-1:0]    lvl_b;
    logic [2:0][1:0][ChanW-1:0]    lvl_g;

    assign en    = !m_valid || m_ready;
    assign q_pop = en && !q_empty;
    assign is_xf = (q_data.func == FUNC_TRANSFORM);
    assign we    = q_pop && !is_xf && q_data.ld_ok;

    for (genvar k = 0; k < Corners; k++) begin : g_bank
        lut3d_ram u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (q_data.addr[0]),
            .wdata (q_data.data),
            .re    (en),
            .raddr (q_data.addr[k]),
            .rdata (corner[k])
        );
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        for (genvar j = 0; j < 4; j++) begin : g_b
            lut3d_blend u_b (
                .aclk (aclk),
                .en   (en),
                .a    (corner[2*j][ch*ChanW +: ChanW]),
                .b    (corner[2*j+1][ch*ChanW +: ChanW]),
                .w    (w1_reg[2]),
                .y    (lvl_b[ch][j])
            );
        end
        for (genvar i = 0; i < 2; i++) begin : g_g
            lut3d_blend u_g (
                .aclk (aclk),
                .en   (en),
                .a    (lvl_b[ch][2*i]),
                .b    (lvl_b[ch][2*i+1]),
                .w    (w3_reg[1]),
                .y    (lvl_g[ch][i])
            );
        end
        lut3d_blend u_r (
            .aclk (aclk),
            .en   (en),
            .a    (lvl_g[ch][0]),
            .b    (lvl_g[ch][1]),
            .w    (w5_reg[0]),
            .y    (m_data[ch*ChanW +: ChanW])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg <= q_data.wt;
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
            w4_reg <= w3_reg;
            w5_reg <= w4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[BackStages-2:0], q_pop && is_xf};
        end
    end

    assign m_valid = vld_reg[BackStages-1];

endmodule

@@ rtl/core/lut3d_trilinear_color_transform.sv @@
// top level of the 3d lut color transform with trilinear interpolation
//
//  channel   direction  beat contents
//  s_        in         tuser: func; tdata: index, entry rgb, color rgb
//  m_        out        tdata: red_out, green_out, blue_out
//  cfg_      in         grid_points, written when cfg_we is high
//
// one beat per cycle in and out when neither side stalls
// a color passes 4 address-generation stages, one queue slot, the table read, and
// three blend levels, each with a product and an output register; loads give no result
// aresetn clears the pipelines, queue and grid size (17); table contents stay undefined
// a stalled m_ side freezes the back, the queue absorbs the front until it fills
`timescale 1ns / 1ps

module lut3d_trilinear_color_transform (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // node_index, entry_red, entry_green, entry_blue,
                                     // red_in, green_in, blue_in
    input  logic [0:0]    s_tuser,   // func
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // red_out, green_out, blue_out
    input  logic          cfg_we,
    input  logic [5:0]    cfg_wdata
);
    import lut3d_pkg::*;

    logic [GridW-1:0]        grid_reg;
    logic                    f_en, push, q_pop, q_empty;
    logic [QueuePtrW:0]      q_count;
    queue_entry_t            push_data, q_data;
    logic [2:0][ChanW-1:0]   color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg <= GridReset;
        end else if (cfg_we) begin
            grid_reg <= cfg_wdata;
        end
    end

    assign f_en     = (q_count <= (QueuePtrW+1)'(QueueDepth - FrontStages));
    assign s_tready = f_en;
    assign color    = s_tdata[111:64];

    lut3d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (f_en),
        .in_valid  (s_tvalid),
        .in_func   (func_t'(s_tuser[0])),
        .in_index  (s_tdata[15:0]),
        .in_entry  (s_tdata[63:16]),
        .in_color  (color),
        .grid      (grid_in_use(grid_reg)),
        .push      (push),
        .push_data (push_data)
    );

    lut3d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    lut3d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

endmodule

@@ tb/lut3d_color_checker.sv @@
// checker that predicts color transform results and compares them on the m_ channel
`timescale 1ns / 1ps

module lut3d_color_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         cfg_we,
    input  logic [5:0]   cfg_wdata,
    output int           errors,
    output int           pending
);
    import lut3d_pkg::*;

    logic [NodeW-1:0] node_mem [TableDepth];
    logic [GridW-1:0] grid_reg;
    logic [47:0]      expected_colors [$];

    assign pending = expected_colors.size();

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint mix(input longint a, input longint b, input longint w);
        return a + ((b - a) * w) / 65535;
    endfunction

    function automatic logic [47:0] interpolate(input logic [47:0] color);
        int unsigned g, s;
        int unsigned lo[3], hi[3];
        longint w[3];
        longint c[8];
        longint c00, c01, c10, c11, c0, c1, v;
        logic [47:0] res;
        g = grid_reg;
        if (g < 2) g = 2;
        if (g > MaxGrid) g = MaxGrid;
        for (int k = 0; k < 3; k++) begin
            s = int'(color[16*k +: 16]) * (g - 1);
            lo[k] = s / 65535;
            w[k] = s % 65535;
            hi[k] = (lo[k] + 1 < g) ? lo[k] + 1 : g - 1;
            if (lo[k] > g - 1) lo[k] = g - 1;
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int n = 0; n < 8; n++) begin
                int unsigned ri, gi, bi, idx;
                ri = n[2] ? hi[0] : lo[0];
                gi = n[1] ? hi[1] : lo[1];
                bi = n[0] ? hi[2] : lo[2];
                idx = (ri * g + gi) * g + bi;
                c[n] = node_mem[idx][16*ch +: 16];
            end
            c00 = mix(c[0], c[1], w[2]);
            c01 = mix(c[2], c[3], w[2]);
            c10 = mix(c[4], c[5], w[2]);
            c11 = mix(c[6], c[7], w[2]);
            c0 = mix(c00, c01, w[1]);
            c1 = mix(c10, c11, w[1]);
            v = mix(c0, c1, w[0]);
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            res[16*ch +: 16] = v[15:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg <= GridReset;
        end else begin
            if (cfg_we) begin
                grid_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                if (func_t'(s_tuser[0]) == FUNC_LOAD) begin
                    if (s_tdata[15:0] < TableDepth) begin
                        node_mem[s_tdata[15:0]] = s_tdata[63:16];
                    end
                end else begin
                    expected_colors.push_back(interpolate(s_tdata[111:64]));
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_colors.size() == 0) begin
                    report("unexpected beat", m_tdata[15:0], 16'h0000);
                end else begin
                    logic [47:0] want;
                    want = expected_colors.pop_front();
                    if (m_tdata[15:0] != want[15:0]) report("red", m_tdata[15:0], want[15:0]);
                    if (m_tdata[31:16] != want[31:16])
                        report("green", m_tdata[31:16], want[31:16]);
                    if (m_tdata[47:32] != want[47:32])
                        report("blue", m_tdata[47:32], want[47:32]);
                end
            end
        end
    end

endmodule

@@ tb/lut3d_trilinear_color_transform_tb.sv @@
// testbench top: stimulus, idling and verdict for the 3d lut color transform
`timescale 1ns / 1ps

module lut3d_trilinear_color_transform_tb;
    import lut3d_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         cfg_we = 1'b0;
    logic [5:0]   cfg_wdata = '0;
    int           errors;
    int           pending;
    bit           quiet_mode = 1'b0;
    bit           hold_sink = 1'b0;
    int           grid_now = 17;
    bit           written [TableDepth];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lut3d_trilinear_color_transform u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    lut3d_color_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_sink) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    task automatic send_beat(input func_t f, input logic [15:0] idx, input logic [47:0] entry,
                             input logic [47:0] color);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {color, entry, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_node(input int r, input int g, input int b, input logic [47:0] entry);
        int idx;
        idx = (r * grid_now + g) * grid_now + b;
        written[idx] = 1'b1;
        send_beat(FUNC_LOAD, 16'(idx), entry, 48'($urandom));
    endtask

    // loads any corner node not yet written, then sends the color
    task automatic transform(input logic [47:0] color);
        int unsigned s;
        int unsigned lo [3];
        int unsigned hi [3];
        int ri, gi, bi;
        for (int k = 0; k < 3; k++) begin
            s = int'(color[16*k +: 16]) * (grid_now - 1);
            lo[k] = s / 65535;
            hi[k] = (lo[k] + 1 < grid_now) ? lo[k] + 1 : grid_now - 1;
        end
        for (int n = 0; n < 8; n++) begin
            ri = int'(n[2] ? hi[0] : lo[0]);
            gi = int'(n[1] ? hi[1] : lo[1]);
            bi = int'(n[0] ? hi[2] : lo[2]);
            if (!written[(ri * grid_now + gi) * grid_now + bi])
                load_node(ri, gi, bi, 48'({$urandom, $urandom}));
        end
        send_beat(FUNC_TRANSFORM, 16'($urandom), 48'({$urandom, $urandom}), color);
    endtask

    function automatic logic [15:0] pick_chan();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hFFFE;
            3: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // idle write of the grid size, then optionally fill every node in use
    task automatic set_grid(input logic [5:0] value, input bit flat, input bit fill);
        int gv;
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        gv = value;
        if (gv < 2) gv = 2;
        if (gv > MaxGrid) gv = MaxGrid;
        grid_now = gv;
        if (fill)
            for (int r = 0; r < gv; r++)
                for (int g = 0; g < gv; g++)
                    for (int b = 0; b < gv; b++)
                        load_node(r, g, b, flat ? {16'($urandom), 16'($urandom), 16'($urandom)}
                                                : {16'(b * 65535 / (gv - 1)),
                                                   16'(g * 65535 / (gv - 1)),
                                                   16'(r * 65535 / (gv - 1))});
    endtask

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int gv;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset grid size 17, corners loaded on demand
        transform(48'h0);
        transform({48{1'b1}});
        transform({16'h0000, 16'hFFFF, 16'h0001});
        transform({16'h8000, 16'h7FFF, 16'h5555});
        // load beyond the table is ignored
        send_beat(FUNC_LOAD, 16'hFFFF, {48{1'b1}}, 48'h0);
        send_beat(FUNC_LOAD, 16'(TableDepth), 48'h0, 48'h0);
        transform({16'hFFFF, 16'h0000, 16'hFFFF});

        // sender waits for all results
        drain();

        // grid below range used as 2
        set_grid(6'd0, 1'b1, 1'b1);

        // long receiver hold-off while sender keeps offering
        hold_sink = 1'b1;
        fork
            begin
                repeat (200) @(posedge aclk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 40; i++) transform(48'({$urandom, $urandom}));
        join

        for (int i = 0; i < 40; i++) transform({pick_chan(), pick_chan(), pick_chan()});
        // grid 2 directly, identity ramp
        set_grid(6'd2, 1'b0, 1'b1);
        for (int i = 0; i < 40; i++) transform({pick_chan(), pick_chan(), pick_chan()});
        // above range used as max, corners loaded on demand, no idling
        set_grid(6'd63, 1'b1, 1'b0);
        quiet_mode = 1'b1;
        for (int i = 0; i < 25; i++) transform({pick_chan(), pick_chan(), pick_chan()});
        quiet_mode = 1'b0;
        set_grid(6'd4, 1'b1, 1'b1);
        for (int i = 0; i < 60; i++) begin
            if ($urandom_range(3) == 0) begin
                load_node($urandom_range(3), $urandom_range(3), $urandom_range(3),
                          48'({$urandom, $urandom}));
            end else begin
                transform({pick_chan(), pick_chan(), pick_chan()});
            end
        end
        gv = $urandom_range(3, 6);
        set_grid(6'(gv), 1'b1, 1'b1);
        for (int i = 0; i < 40; i++) transform({pick_chan(), pick_chan(), pick_chan()});

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lut3d_pkg.sv
rtl/core/lut3d_ram.sv
rtl/core/lut3d_queue.sv
rtl/core/lut3d_front.sv
rtl/core/lut3d_blend.sv
rtl/core/lut3d_back.sv
rtl/core/lut3d_trilinear_color_transform.sv
tb/lut3d_color_checker.sv
tb/lut3d_trilinear_color_transform_tb.sv
